/* rtl/msp_command_frame_parser_unit_assert.svh */
// Assertion macros shared by the checker of the frame parser.
`ifndef MSP_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define MSP_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/msp_cfp_pkg.sv */
// Package with the types and constants of the frame parser.
package msp_cfp_pkg;

    localparam logic [7:0] HDR0 = 8'h24;
    localparam logic [7:0] HDR1 = 8'h4D;
    localparam logic [7:0] HDR2 = 8'h3C;

    localparam logic [8:0] POS_HUNT   = 9'd0;
    localparam logic [8:0] POS_HDR1   = 9'd1;
    localparam logic [8:0] POS_HDR2   = 9'd2;
    localparam logic [8:0] POS_LENGTH = 9'd3;
    localparam logic [8:0] POS_CMD    = 9'd4;
    localparam logic [8:0] POS_PL_LO  = 9'd5;
    localparam logic [8:0] POS_PL_HI  = 9'd12;

    localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

    localparam logic [15:0] STICK_HIGH   = 16'd1900;
    localparam logic [15:0] STICK_LOW    = 16'd1100;
    localparam logic [15:0] STICK_CENTER = 16'd1500;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STICKS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_LOCK         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_UNLOCK       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_CALIBRATE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STATE_UPLOAD = 3'd4;

    localparam logic [7:0] RST_CODE_STICKS       = 8'd200;
    localparam logic [7:0] RST_CODE_LOCK         = 8'd201;
    localparam logic [7:0] RST_CODE_UNLOCK       = 8'd202;
    localparam logic [7:0] RST_CODE_CALIBRATE    = 8'd205;
    localparam logic [7:0] RST_CODE_STATE_UPLOAD = 8'd206;

    typedef struct packed {
        logic        frame_good;
        logic        frame_bad;
        logic [7:0]  command_seen;
        logic [15:0] throttle_chan;
        logic [15:0] yaw_chan;
        logic [15:0] pitch_chan;
        logic [15:0] roll_chan;
        logic        locked;
        logic        calibrate_pulse;
        logic        state_pulse;
        logic        link_ok;
    } t_result;

endpackage

/* rtl/msp_cfp_core.sv */
// Frame state, command registers and the per-byte parse and dispatch logic.
module msp_cfp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msp_cfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_accept,
    input  logic [7:0]                          i_rx_byte,
    output msp_cfp_pkg::t_result                o_result
);

    logic [7:0]  r_code_sticks, r_code_lock, r_code_unlock, r_code_cal, r_code_state;

    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_payload [8];
    logic [7:0]  n_payload [8];
    logic [15:0] r_chan [4];
    logic [15:0] n_chan [4];
    logic        r_lock, n_lock;

    logic [8:0]  pos_inc;
    logic [2:0]  slot;
    logic        good, bad, cal, st;

    assign pos_inc = r_pos + 9'd1;
    assign slot    = r_pos[2:0] - 3'd5;

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_xor     = r_xor;
        n_cmd     = r_cmd;
        n_payload = r_payload;
        n_chan    = r_chan;
        n_lock    = r_lock;
        good      = 1'b0;
        bad       = 1'b0;
        cal       = 1'b0;
        st        = 1'b0;
        if (i_accept) begin
            if (r_pos == msp_cfp_pkg::POS_HUNT) begin
                if (i_rx_byte == msp_cfp_pkg::HDR0) begin
                    n_pos = msp_cfp_pkg::POS_HDR1;
                end
            end else if (r_pos == msp_cfp_pkg::POS_HDR1) begin
                n_pos = (i_rx_byte == msp_cfp_pkg::HDR1) ? msp_cfp_pkg::POS_HDR2
                                                         : msp_cfp_pkg::POS_HUNT;
            end else if (r_pos == msp_cfp_pkg::POS_HDR2) begin
                n_pos = (i_rx_byte == msp_cfp_pkg::HDR2) ? msp_cfp_pkg::POS_LENGTH
                                                         : msp_cfp_pkg::POS_HUNT;
            end else begin
                if (r_pos == msp_cfp_pkg::POS_LENGTH) begin
                    n_xor = 8'd0;
                    n_len = i_rx_byte;
                end
                if (r_pos == msp_cfp_pkg::POS_CMD) begin
                    n_cmd = i_rx_byte;
                end
                if (r_pos >= msp_cfp_pkg::POS_PL_LO && r_pos <= msp_cfp_pkg::POS_PL_HI) begin
                    n_payload[slot] = i_rx_byte;
                end
                // The checksum byte sits at position length + 5.
                if (pos_inc >= {1'b0, n_len} + msp_cfp_pkg::FRAME_OVERHEAD) begin
                    n_pos = msp_cfp_pkg::POS_HUNT;
                    if (i_rx_byte == n_xor) begin
                        good = 1'b1;
                        if (n_cmd == r_code_sticks) begin
                            for (int k = 0; k < 4; k++) begin
                                n_chan[k] = {n_payload[2*k+1], n_payload[2*k]};
                            end
                        end else if (n_cmd == r_code_lock) begin
                            n_lock = 1'b1;
                        end else if (n_cmd == r_code_unlock) begin
                            n_lock = 1'b0;
                        end else if (n_cmd == r_code_cal) begin
                            cal = 1'b1;
                        end else if (n_cmd == r_code_state) begin
                            st = 1'b1;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    n_xor = n_xor ^ i_rx_byte;
                    n_pos = pos_inc;
                end
            end
        end
    end

    always_comb begin
        o_result.frame_good      = good;
        o_result.frame_bad       = bad;
        o_result.command_seen    = n_cmd;
        o_result.throttle_chan   = n_chan[0];
        o_result.yaw_chan        = n_chan[1];
        o_result.pitch_chan      = n_chan[2];
        o_result.roll_chan       = n_chan[3];
        o_result.locked          = n_lock;
        o_result.calibrate_pulse = cal;
        o_result.state_pulse     = st;
        o_result.link_ok         = !(n_chan[0] > msp_cfp_pkg::STICK_HIGH &&
                                     n_chan[1] < msp_cfp_pkg::STICK_LOW &&
                                     n_chan[2] > msp_cfp_pkg::STICK_HIGH &&
                                     n_chan[3] > msp_cfp_pkg::STICK_HIGH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_sticks <= msp_cfp_pkg::RST_CODE_STICKS;
            r_code_lock   <= msp_cfp_pkg::RST_CODE_LOCK;
            r_code_unlock <= msp_cfp_pkg::RST_CODE_UNLOCK;
            r_code_cal    <= msp_cfp_pkg::RST_CODE_CALIBRATE;
            r_code_state  <= msp_cfp_pkg::RST_CODE_STATE_UPLOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msp_cfp_pkg::CFG_CODE_STICKS:       r_code_sticks <= i_cfg_data;
                msp_cfp_pkg::CFG_CODE_LOCK:         r_code_lock   <= i_cfg_data;
                msp_cfp_pkg::CFG_CODE_UNLOCK:       r_code_unlock <= i_cfg_data;
                msp_cfp_pkg::CFG_CODE_CALIBRATE:    r_code_cal    <= i_cfg_data;
                msp_cfp_pkg::CFG_CODE_STATE_UPLOAD: r_code_state  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= msp_cfp_pkg::POS_HUNT;
            r_len  <= 8'd0;
            r_xor  <= 8'd0;
            r_cmd  <= 8'd0;
            r_lock <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_payload[k] <= 8'd0;
            end
            for (int k = 0; k < 4; k++) begin
                r_chan[k] <= msp_cfp_pkg::STICK_CENTER;
            end
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_xor     <= n_xor;
            r_cmd     <= n_cmd;
            r_lock    <= n_lock;
            r_payload <= n_payload;
            r_chan    <= n_chan;
        end
    end

endmodule

/* rtl/msp_cfp_skid.sv */
// Result register with one skid entry between the parser and the output channel.
module msp_cfp_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  msp_cfp_pkg::t_result i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output msp_cfp_pkg::t_result o_data
);

    logic                 r_out_v, r_skid_v;
    msp_cfp_pkg::t_result r_out, r_skid;
    logic                 load;

    // The output register may take new data when it is empty or being drained.
    assign load    = !r_out_v || !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

/* rtl/msp_command_frame_parser_unit.sv */
// Top level of the command frame parser: one received byte in, one result item out.
//
//  channel   direction  handshake                 payload
//  rx        in         i_rx_valid / o_rx_stall   i_rx_byte
//  res       out        o_res_valid / i_res_stall o_frame_good .. o_link_ok
//  cfg       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while o_rx_stall is low; its result is registered in the result register,
// or in the skid entry when the result side stalls. The whole parse, checksum and dispatch for a byte is done
// in a single pass of the core. Synchronous active-low reset restores the command codes, channels (1500) and
// frame state. When the result side stalls, one more item is held in a skid entry, then o_rx_stall rises.
module msp_command_frame_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msp_cfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_rx_valid,
    output logic                                o_rx_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic                                o_frame_good,
    output logic                                o_frame_bad,
    output logic [7:0]                          o_command_seen,
    output logic [15:0]                         o_throttle_chan,
    output logic [15:0]                         o_yaw_chan,
    output logic [15:0]                         o_pitch_chan,
    output logic [15:0]                         o_roll_chan,
    output logic                                o_locked,
    output logic                                o_calibrate_pulse,
    output logic                                o_state_pulse,
    output logic                                o_link_ok
);

    logic                 accept;
    logic                 full;
    msp_cfp_pkg::t_result core_res, out_res;

    assign o_rx_stall = full;
    assign accept     = i_rx_valid && !full;

    msp_cfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_result    (core_res)
    );

    msp_cfp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_res),
        .o_full  (full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_data  (out_res)
    );

    assign o_frame_good      = out_res.frame_good;
    assign o_frame_bad       = out_res.frame_bad;
    assign o_command_seen    = out_res.command_seen;
    assign o_throttle_chan   = out_res.throttle_chan;
    assign o_yaw_chan        = out_res.yaw_chan;
    assign o_pitch_chan      = out_res.pitch_chan;
    assign o_roll_chan       = out_res.roll_chan;
    assign o_locked          = out_res.locked;
    assign o_calibrate_pulse = out_res.calibrate_pulse;
    assign o_state_pulse     = out_res.state_pulse;
    assign o_link_ok         = out_res.link_ok;

endmodule

/* rtl/msp_cfp_checker.sv */
// Port-level checker of the frame parser and its bind to the top level.
`include "msp_command_frame_parser_unit_assert.svh"

module msp_cfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic        o_frame_good,
    input logic        o_frame_bad,
    input logic [15:0] o_throttle_chan,
    input logic [15:0] o_yaw_chan,
    input logic [15:0] o_pitch_chan,
    input logic [15:0] o_roll_chan,
    input logic        o_locked,
    input logic        o_calibrate_pulse,
    input logic        o_state_pulse,
    input logic        o_link_ok
);

    logic        link_lost;
    logic        any_pulse;
    logic        pulse_ok;
    logic        res_stalled;
    logic [17:0] res_held;

    assign link_lost   = o_throttle_chan > msp_cfp_pkg::STICK_HIGH &&
                         o_yaw_chan < msp_cfp_pkg::STICK_LOW &&
                         o_pitch_chan > msp_cfp_pkg::STICK_HIGH &&
                         o_roll_chan > msp_cfp_pkg::STICK_HIGH;
    assign any_pulse   = o_calibrate_pulse || o_state_pulse;
    assign pulse_ok    = o_frame_good && !(o_calibrate_pulse && o_state_pulse);
    assign res_stalled = o_res_valid && i_res_stall;
    assign res_held    = {o_throttle_chan, o_locked, o_frame_good};

    // A frame ends either good or bad, never both.
    `MSP_ASSERT_NOW(a_good_bad_excl, i_clk, i_rst_n, o_res_valid, !(o_frame_good && o_frame_bad))

    // Command pulses come only from a frame with a matching checksum.
    `MSP_ASSERT_NOW(a_pulse_needs_good, i_clk, i_rst_n, o_res_valid && any_pulse, pulse_ok)

    // The link flag follows the channel values shown with it.
    `MSP_ASSERT_NOW(a_link_pattern, i_clk, i_rst_n, o_res_valid, o_link_ok == !link_lost)

    // A stalled result item holds.
    `MSP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, res_stalled, o_res_valid && $stable(res_held))

endmodule

bind msp_command_frame_parser_unit msp_cfp_checker u_msp_cfp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_res_valid       (o_res_valid),
    .i_res_stall       (i_res_stall),
    .o_frame_good      (o_frame_good),
    .o_frame_bad       (o_frame_bad),
    .o_throttle_chan   (o_throttle_chan),
    .o_yaw_chan        (o_yaw_chan),
    .o_pitch_chan      (o_pitch_chan),
    .o_roll_chan       (o_roll_chan),
    .o_locked          (o_locked),
    .o_calibrate_pulse (o_calibrate_pulse),
    .o_state_pulse     (o_state_pulse),
    .o_link_ok         (o_link_ok)
);

/* verif/msp_cfp_result_checker.sv */
// Checker that predicts each result item of the frame parser and compares it with the block.
`timescale 1ns / 1ps
module msp_cfp_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msp_cfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_rx_valid,
    input  logic                                i_rx_stall,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  msp_cfp_pkg::t_result                i_res,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import msp_cfp_pkg::*;

    // Shadow copy of the parser state and the command codes.
    logic [8:0]  pos;
    logic [7:0]  frame_len;
    logic [7:0]  xor_sum;
    logic [7:0]  cmd;
    logic [7:0]  stash [8];
    logic [15:0] chan [4];
    logic        lock;
    logic [7:0]  codes [5];

    t_result expected_q [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic parse_rx_byte(input logic [7:0] b, output t_result r);
        logic       good;
        logic       bad;
        logic       cal;
        logic       st;
        logic [2:0] slot;
        good = 1'b0;
        bad  = 1'b0;
        cal  = 1'b0;
        st   = 1'b0;
        if (pos == POS_HUNT) begin
            if (b == HDR0) pos = POS_HDR1;
        end else if (pos == POS_HDR1) begin
            pos = (b == HDR1) ? POS_HDR2 : POS_HUNT;
        end else if (pos == POS_HDR2) begin
            pos = (b == HDR2) ? POS_LENGTH : POS_HUNT;
        end else begin
            if (pos == POS_LENGTH) begin
                xor_sum   = 8'd0;
                frame_len = b;
            end
            if (pos == POS_CMD) cmd = b;
            if (pos >= POS_PL_LO && pos <= POS_PL_HI) begin
                slot = 3'(pos - POS_PL_LO);
                stash[slot] = b;
            end
            pos = pos + 9'd1;
            if (int'(pos) >= int'(frame_len) + int'(FRAME_OVERHEAD)) begin
                if (b == xor_sum) begin
                    good = 1'b1;
                    // The first matching code wins when several registers agree.
                    if (cmd == codes[CFG_CODE_STICKS]) begin
                        for (int k = 0; k < 4; k++) chan[k] = {stash[2*k+1], stash[2*k]};
                    end else if (cmd == codes[CFG_CODE_LOCK]) begin
                        lock = 1'b1;
                    end else if (cmd == codes[CFG_CODE_UNLOCK]) begin
                        lock = 1'b0;
                    end else if (cmd == codes[CFG_CODE_CALIBRATE]) begin
                        cal = 1'b1;
                    end else if (cmd == codes[CFG_CODE_STATE_UPLOAD]) begin
                        st = 1'b1;
                    end
                end else begin
                    bad = 1'b1;
                end
                pos = POS_HUNT;
            end else begin
                xor_sum = xor_sum ^ b;
            end
        end
        r.frame_good      = good;
        r.frame_bad       = bad;
        r.command_seen    = cmd;
        r.throttle_chan   = chan[0];
        r.yaw_chan        = chan[1];
        r.pitch_chan      = chan[2];
        r.roll_chan       = chan[3];
        r.locked          = lock;
        r.calibrate_pulse = cal;
        r.state_pulse     = st;
        r.link_ok         = (chan[0] > STICK_HIGH && chan[1] < STICK_LOW &&
                             chan[2] > STICK_HIGH && chan[3] > STICK_HIGH) ? 1'b0 : 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            pos       = POS_HUNT;
            frame_len = 8'd0;
            xor_sum   = 8'd0;
            cmd       = 8'd0;
            lock      = 1'b0;
            for (int k = 0; k < 8; k++) stash[k] = 8'd0;
            for (int k = 0; k < 4; k++) chan[k] = STICK_CENTER;
            codes[CFG_CODE_STICKS]       = RST_CODE_STICKS;
            codes[CFG_CODE_LOCK]         = RST_CODE_LOCK;
            codes[CFG_CODE_UNLOCK]       = RST_CODE_UNLOCK;
            codes[CFG_CODE_CALIBRATE]    = RST_CODE_CALIBRATE;
            codes[CFG_CODE_STATE_UPLOAD] = RST_CODE_STATE_UPLOAD;
            expected_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("frame_good", 16'(want.frame_good), 16'(i_res.frame_good));
                    check_field("frame_bad", 16'(want.frame_bad), 16'(i_res.frame_bad));
                    check_field("command_seen", 16'(want.command_seen),
                                16'(i_res.command_seen));
                    check_field("throttle_chan", want.throttle_chan, i_res.throttle_chan);
                    check_field("yaw_chan", want.yaw_chan, i_res.yaw_chan);
                    check_field("pitch_chan", want.pitch_chan, i_res.pitch_chan);
                    check_field("roll_chan", want.roll_chan, i_res.roll_chan);
                    check_field("locked", 16'(want.locked), 16'(i_res.locked));
                    check_field("calibrate_pulse", 16'(want.calibrate_pulse),
                                16'(i_res.calibrate_pulse));
                    check_field("state_pulse", 16'(want.state_pulse),
                                16'(i_res.state_pulse));
                    check_field("link_ok", 16'(want.link_ok), 16'(i_res.link_ok));
                end
            end
            // An item taken at this edge still sees the codes from before the write.
            if (i_rx_valid && !i_rx_stall) begin
                parse_rx_byte(i_rx_byte, pred);
                expected_q.push_back(pred);
            end
            if (i_cfg_we && i_cfg_index <= CFG_CODE_STATE_UPLOAD) codes[i_cfg_index] = i_cfg_data;
        end
        o_pending <= expected_q.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top of the frame parser: clock, reset, byte stimulus, code settings and verdict.
`timescale 1ns / 1ps
module tb;
    import msp_cfp_pkg::*;

    localparam int CH_RANDOM    = 0;
    localparam int CH_LINK_LOST = 1;
    localparam int CH_ALL_ONES  = 2;
    localparam int CH_ALL_ZERO  = 3;

    localparam int HOLD_OFF_CYCLES = 150;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [7:0]             i_cfg_data  = 8'd0;
    logic                   i_rx_valid  = 1'b0;
    logic [7:0]             i_rx_byte   = 8'd0;
    logic                   i_res_stall = 1'b0;

    logic        o_rx_stall;
    logic        o_res_valid;
    logic        o_frame_good;
    logic        o_frame_bad;
    logic [7:0]  o_command_seen;
    logic [15:0] o_throttle_chan;
    logic [15:0] o_yaw_chan;
    logic [15:0] o_pitch_chan;
    logic [15:0] o_roll_chan;
    logic        o_locked;
    logic        o_calibrate_pulse;
    logic        o_state_pulse;
    logic        o_link_ok;

    t_result dut_res;
    int      fail_count;
    int      pending_count;
    int      bytes_sent = 0;
    bit      quiet      = 1'b0;
    bit      hold_req   = 1'b0;
    logic [7:0] cur_codes [5];

    assign dut_res = {o_frame_good, o_frame_bad, o_command_seen, o_throttle_chan, o_yaw_chan,
                      o_pitch_chan, o_roll_chan, o_locked, o_calibrate_pulse, o_state_pulse,
                      o_link_ok};

    msp_command_frame_parser_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_frame_good      (o_frame_good),
        .o_frame_bad       (o_frame_bad),
        .o_command_seen    (o_command_seen),
        .o_throttle_chan   (o_throttle_chan),
        .o_yaw_chan        (o_yaw_chan),
        .o_pitch_chan      (o_pitch_chan),
        .o_roll_chan       (o_roll_chan),
        .o_locked          (o_locked),
        .o_calibrate_pulse (o_calibrate_pulse),
        .o_state_pulse     (o_state_pulse),
        .o_link_ok         (o_link_ok)
    );

    msp_cfp_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx_valid   (i_rx_valid),
        .i_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .i_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_res        (dut_res),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_chan(input int k, input int mode);
        case (mode)
            CH_LINK_LOST: return (k == 1) ? 16'($urandom_range(0, 1099))
                                          : 16'($urandom_range(1901, 65535));
            CH_ALL_ONES:  return 16'hFFFF;
            CH_ALL_ZERO:  return 16'h0000;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'($urandom);
                    1:       return 16'($urandom_range(1899, 1901));
                    2:       return 16'($urandom_range(1099, 1101));
                    default: return 16'($urandom_range(1000, 2000));
                endcase
            end
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 0;
        if (r < 55) return $urandom_range(1, 7);
        if (r < 80) return 8;
        if (r < 95) return $urandom_range(9, 16);
        return $urandom_range(17, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin : receiver
        int n;
        forever begin
            if (hold_req) begin
                i_res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pick_idle();
                if (n > 0) begin
                    i_res_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_res_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input int len, input bit corrupt,
                              input int chan_mode);
        logic [15:0] ch [4];
        logic [7:0]  b;
        logic [7:0]  sum;
        for (int k = 0; k < 4; k++) ch[k] = pick_chan(k, chan_mode);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(len[7:0]);
        send_byte(cmd);
        sum = len[7:0] ^ cmd;
        for (int k = 0; k < len; k++) begin
            if (k < 8) b = (k % 2 == 1) ? ch[k/2][15:8] : ch[k/2][7:0];
            else b = 8'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if (corrupt) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(sum);
    endtask

    // Stray bytes, broken headers and cut-off frames.
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            1: begin
                send_byte(HDR0);
                send_byte(8'($urandom));
            end
            2: begin
                send_byte(HDR0);
                send_byte(HDR1);
                send_byte(8'($urandom));
            end
            3: begin
                send_byte(HDR0);
                send_byte(HDR0);
                send_byte(HDR1);
                send_byte(HDR2);
            end
            default: begin
                send_byte(HDR0);
                send_byte(HDR1);
                send_byte(HDR2);
                send_byte(8'($urandom_range(0, 12)));
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        endcase
    endtask

    // Stops offering items and waits until every expected result item has come out.
    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_codes(input logic [7:0] c_sticks, input logic [7:0] c_lock,
                             input logic [7:0] c_unlock, input logic [7:0] c_cal,
                             input logic [7:0] c_state);
        logic [7:0] vals [5];
        vals[CFG_CODE_STICKS]       = c_sticks;
        vals[CFG_CODE_LOCK]         = c_lock;
        vals[CFG_CODE_UNLOCK]       = c_unlock;
        vals[CFG_CODE_CALIBRATE]    = c_cal;
        vals[CFG_CODE_STATE_UPLOAD] = c_state;
        wait_idle();
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_INDEX_W'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            cur_codes[k] = vals[k];
        end
        // An index past the last register must change nothing.
        i_cfg_index <= CFG_INDEX_W'($urandom_range(CFG_CODE_STATE_UPLOAD + 1,
                                                   (1 << CFG_INDEX_W) - 1));
        i_cfg_data  <= 8'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int budget);
        int         start;
        int         r;
        logic [7:0] cmd;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 70) cmd = cur_codes[$urandom_range(0, 4)];
            else cmd = 8'($urandom);
            if (r < 75) begin
                send_frame(cmd, pick_length(), 1'b0,
                           ($urandom_range(0, 3) == 0) ? CH_LINK_LOST : CH_RANDOM);
            end else if (r < 87) begin
                send_frame(cmd, pick_length(), 1'b1, CH_RANDOM);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] cc;
        cur_codes[CFG_CODE_STICKS]       = RST_CODE_STICKS;
        cur_codes[CFG_CODE_LOCK]         = RST_CODE_LOCK;
        cur_codes[CFG_CODE_UNLOCK]       = RST_CODE_UNLOCK;
        cur_codes[CFG_CODE_CALIBRATE]    = RST_CODE_CALIBRATE;
        cur_codes[CFG_CODE_STATE_UPLOAD] = RST_CODE_STATE_UPLOAD;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A wrong second header byte, then a wrong third one that is itself a '$'.
        send_byte(HDR0);
        send_byte(8'h00);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_frame(RST_CODE_LOCK, 0, 1'b0, CH_RANDOM);
        send_frame(RST_CODE_STICKS, 8, 1'b0, CH_LINK_LOST);
        send_frame(RST_CODE_CALIBRATE, 0, 1'b1, CH_RANDOM);
        send_frame(RST_CODE_CALIBRATE, 0, 1'b0, CH_RANDOM);
        send_frame(RST_CODE_STATE_UPLOAD, 0, 1'b0, CH_RANDOM);
        send_frame(RST_CODE_UNLOCK, 0, 1'b0, CH_RANDOM);
        send_frame(RST_CODE_STICKS, 8, 1'b0, CH_ALL_ONES);
        send_frame(RST_CODE_STICKS, 8, 1'b0, CH_ALL_ZERO);
        // Short sticks frame: the upper channels keep bytes of earlier frames.
        send_frame(RST_CODE_STICKS, 2, 1'b0, CH_RANDOM);
        send_frame(8'h00, 1, 1'b0, CH_RANDOM);

        random_traffic(30);

        // Every code the same: the sticks command takes precedence.
        set_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(30);

        // The receiver holds off for a long stretch while bytes keep coming.
        set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        hold_req = 1'b1;
        random_traffic(30);

        set_codes(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80);
        quiet = 1'b1;
        random_traffic(25);
        quiet = 1'b0;

        set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        // Longest frame: the position counter runs up to 260, the checksum position of a 255-byte payload.
        send_frame(cur_codes[CFG_CODE_STICKS], 255, 1'b0, CH_RANDOM);
        random_traffic(25);

        ca = 8'($urandom);
        cb = 8'($urandom);
        cc = 8'($urandom);
        set_codes(ca, cb, cb, cc, cc);
        random_traffic(25);

        set_codes(RST_CODE_STICKS, RST_CODE_LOCK, RST_CODE_UNLOCK, RST_CODE_CALIBRATE,
                  RST_CODE_STATE_UPLOAD);
        random_traffic(25);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
